### hw/rtl/ept_pkg.sv
// ----------------------------------------------------------------------------
// ept_pkg: shared types and constants of the edge-period tachometer
// Beat payload structs, arithmetic widths and the divider control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ept_pkg;

  localparam int TIME_W    = 32;
  localparam int PPR_W     = 8;
  localparam int DIVISOR_W = TIME_W + PPR_W;
  localparam int SPEED_W   = 34;

  // 60e6 microseconds per minute times 256 for the Q.8 fraction.
  localparam logic [SPEED_W-1:0] RPM_Q8_NUMERATOR = 34'd15360000000;

  // One quotient bit is produced per divider step.
  localparam int DIV_STEPS = SPEED_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [PPR_W-1:0] PPR_RESET = 8'd1;

  typedef struct packed {
    logic              channel;
    logic [TIME_W-1:0] time_us;
  } ept_in_t;

  typedef struct packed {
    logic               out_channel;
    logic [SPEED_W-1:0] speed_rpm_q8;
  } ept_out_t;

  typedef struct packed {
    logic                 start;
    logic [DIVISOR_W-1:0] divisor;
  } ept_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ept_div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/ept_divider.sv
// ----------------------------------------------------------------------------
// ept_divider: restoring divider for the tachometer speed
// Divides the fixed RPM numerator by a 40-bit divisor, one quotient bit per
// cycle through a single shared subtract-and-compare unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ept_divider
  import ept_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ept_div_ctrl_t      ctrl,
  output ept_div_stat_t           stat,
  output logic [SPEED_W-1:0]      quotient
);

  logic [DIVISOR_W-1:0] div_r;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [SPEED_W-1:0]   quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // The quotient register starts out holding the numerator and shifts its
  // bits into the remainder while quotient bits shift in from the bottom.
  always_comb begin
    trial   = {rem_r, quo_r[SPEED_W-1]};
    diff    = trial - {1'b0, div_r};
    fits    = (trial >= {1'b0, div_r});
    rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_nxt = {quo_r[SPEED_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      div_r <= ctrl.divisor;
      rem_r <= '0;
      quo_r <= RPM_Q8_NUMERATOR;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

### hw/rtl/edge_period_tachometer.sv
// ----------------------------------------------------------------------------
// edge_period_tachometer: wheel speed from the period between sensor edges
// Keeps the last edge stamp per channel and turns each new period into RPM.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on in_data carries a wheel channel and the microsecond
// stamp of one sensor edge. The block measures the period since the last
// edge of that channel (zero when the stamp did not advance, which covers
// timer wrap and repeated stamps) and always records the new stamp.
// A nonzero period yields one output beat with the channel and the speed
// floor(15360000000 / (period * pulses_per_rev)), RPM in unsigned Q.8.
// A zero period, or a channel at or above CHANNELS, yields no beat.
// An edge with a zero period is taken without starting the divider. An
// edge with a speed result passes from acceptance through S_MUL, which
// starts the divider with the 32x8 period product, S_DIV, which waits on
// the 34 steps of the restoring divider (one quotient bit per step) and on
// its done report, and S_OUT, which loads the output register. A new
// edge is taken only after the previous one has left S_OUT. in_stall is
// high while an edge is in progress. If the receiver stalls, the result
// holds in the output register; a finished quotient waits until that
// register is free. Reset clears both edge stamps to 0 and sets
// pulses_per_rev to 1; a write of 0 to pulses_per_rev is treated as 1.
// cfg_we writes the register at once; the user must use it only while no
// edge is in progress, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edge_period_tachometer
  import ept_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // Edge events.
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ept_in_t          in_data,
  // Speed results.
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ept_out_t              out_data,
  // Configuration: pulses per revolution.
  input  wire logic             cfg_we,
  input  wire logic [PPR_W-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [TIME_W-1:0] last_r [CHANNELS];
  logic [PPR_W-1:0]  ppr_r;
  logic [TIME_W-1:0] period_r;
  logic              chan_r;

  logic              out_valid_r, out_valid_nxt;
  ept_out_t          out_data_r;

  logic              in_accept;
  logic              ch_ok;
  logic [TIME_W-1:0] last_sel;
  logic [TIME_W-1:0] period;
  logic [PPR_W-1:0]  ppr_eff;
  logic              out_load;

  ept_div_ctrl_t     div_ctrl;
  ept_div_stat_t     div_stat;
  logic [SPEED_W-1:0] quotient;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign ch_ok     = (int'(in_data.channel) < CHANNELS);

  // Pick the stored stamp of the addressed channel.
  always_comb begin
    last_sel = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (int'(in_data.channel) == i) begin
        last_sel = last_r[i];
      end
    end
  end

  // A stamp that did not advance gives a zero period and no result.
  assign period = (in_data.time_us > last_sel) ? (in_data.time_us - last_sel) : '0;

  assign ppr_eff = (ppr_r == '0) ? PPR_RESET : ppr_r;

  // The product is registered inside the divider when it starts.
  assign div_ctrl.start   = (state_r == S_MUL);
  assign div_ctrl.divisor = DIVISOR_W'(period_r) * DIVISOR_W'(ppr_eff);

  ept_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // The output register loads once it is empty or being drained.
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && ch_ok && (period != '0)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ppr_r       <= PPR_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        last_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        ppr_r <= cfg_wdata;
      end
      // The stamp is recorded on every valid edge, even with a zero period.
      for (int i = 0; i < CHANNELS; i++) begin
        if (in_accept && ch_ok && (int'(in_data.channel) == i)) begin
          last_r[i] <= in_data.time_us;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      period_r <= period;
      chan_r   <= in_data.channel;
    end
    if (out_load) begin
      out_data_r.out_channel  <= chan_r;
      out_data_r.speed_rpm_q8 <= quotient;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The divider only runs while the sequencer waits on it.
  a_div_busy_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == S_DIV))
    else $error("divider busy outside of the divide state");

  // A finished division is only reported while the sequencer waits on it.
  a_div_done_in_div : assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_DIV))
    else $error("divider done outside of the divide state");

  // An edge with a nonzero period starts the product step next cycle.
  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && ch_ok && (period != '0)) |=> (state_r == S_MUL))
    else $error("edge with a nonzero period did not start a measurement");

  // A loaded result shows as a valid output beat with the quotient.
  a_load_shows : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid && (out_data.speed_rpm_q8 == $past(quotient))))
    else $error("finished result not presented on the output");

endmodule

`default_nettype wire

### dv/edge_period_tachometer_checker.sv
// ----------------------------------------------------------------------------
// edge_period_tachometer_checker: speed predictor and result scoreboard
// Watches the edge, result and configuration ports, predicts each speed beat
// and compares it field by field with the beat that the block delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_period_tachometer_checker
  import ept_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  ept_in_t          in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  ept_out_t         out_data,
  input  logic             cfg_we,
  input  logic [PPR_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count
);

  localparam int SHOWN_FAILS = 10;

  logic [TIME_W-1:0] edge_stamp [CHANNELS];
  logic [PPR_W-1:0]  pulses_per_rev;
  ept_out_t          speed_q [$];
  int                fails = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  // Exact integer speed; a pulse count of zero scales like one.
  function automatic logic [SPEED_W-1:0] rpm_q8(input logic [TIME_W-1:0] period,
                                                input logic [PPR_W-1:0]  pulses);
    logic [PPR_W-1:0] scale;
    logic [63:0]      divisor;
    scale   = (pulses == '0) ? PPR_W'(1) : pulses;
    divisor = 64'(period) * 64'(scale);
    return SPEED_W'(64'(RPM_Q8_NUMERATOR) / divisor);
  endfunction

  task automatic report(input string msg);
    if (fails < SHOWN_FAILS)
      $display("[%0t] speed check: %s", $time, msg);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    ept_out_t          want;
    logic [TIME_W-1:0] period;
    if (!rst_n) begin
      foreach (edge_stamp[c]) edge_stamp[c] = '0;
      pulses_per_rev = PPR_RESET;
      speed_q.delete();
    end else begin
      if (cfg_we)
        pulses_per_rev = cfg_wdata;

      // Results are taken before edges: an edge accepted now cannot have
      // its speed beat out at the same edge.
      if (out_valid && !out_stall) begin
        if (speed_q.size() == 0) begin
          report($sformatf("beat with nothing expected: channel %0d speed %0d",
                           out_data.out_channel, out_data.speed_rpm_q8));
        end else begin
          want = speed_q.pop_front();
          if (out_data.out_channel !== want.out_channel)
            report($sformatf("out_channel expected %0d got %0d",
                             want.out_channel, out_data.out_channel));
          if (out_data.speed_rpm_q8 !== want.speed_rpm_q8)
            report($sformatf("speed_rpm_q8 expected %0d got %0d (channel %0d)",
                             want.speed_rpm_q8, out_data.speed_rpm_q8,
                             want.out_channel));
        end
      end

      if (in_valid && !in_stall && in_data.channel < CHANNELS) begin
        period = (in_data.time_us > edge_stamp[in_data.channel]) ?
                 in_data.time_us - edge_stamp[in_data.channel] : '0;
        edge_stamp[in_data.channel] = in_data.time_us;
        if (period != '0) begin
          want.out_channel  = in_data.channel;
          want.speed_rpm_q8 = rpm_q8(period, pulses_per_rev);
          speed_q.push_back(want);
        end
      end
    end
    fail_count    <= fails;
    pending_count <= speed_q.size();
  end

endmodule

### dv/edge_period_tachometer_tb.sv
// ----------------------------------------------------------------------------
// edge_period_tachometer_tb: stimulus and verdict for the wheel tachometer
// Sends directed and random edge beats under several pulse counts, with
// random idling on both channels, and leaves the checking to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edge_period_tachometer_tb;
  import ept_pkg::*;

  localparam int CHANNELS        = 2;
  localparam int PHASES          = 5;
  localparam int ITEMS_PER_PHASE = 140;
  // Hold-off that covers a speed beat still in flight, applied before
  // touching the register or ending the run.
  localparam int DRAIN_CYCLES    = 45;
  localparam int CYCLE_LIMIT     = 500000;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  ept_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  ept_out_t         out_data;
  logic             cfg_we    = 1'b0;
  logic [PPR_W-1:0] cfg_wdata = '0;

  int check_fails;
  int check_pending;

  // Chance in percent that the sender idles before a beat; the receiver
  // starts a stall burst at a fifth of that rate per cycle.
  int idle_pct    = 0;
  int stall_left  = 0;
  int cycle_count = 0;

  // Last stamp sent on each channel, used to build rising stamp sequences.
  logic [TIME_W-1:0] last_sent [CHANNELS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  edge_period_tachometer #(
    .CHANNELS (CHANNELS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  edge_period_tachometer_checker #(
    .CHANNELS (CHANNELS)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (check_fails),
    .pending_count (check_pending)
  );

  // Receiver back-pressure: random stall bursts. A burst that is
  // already running finishes even after idling has been switched off.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_pct != 0 && $urandom_range(0, 499) < idle_pct) begin
      stall_left <= $urandom_range(0, 13);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Drives one edge beat and returns in the time step of its acceptance.
  // Valid is only lowered for an idle gap, so a back-to-back beat keeps it
  // high without a second assignment in the same step.
  task automatic send_edge(input logic ch, input logic [TIME_W-1:0] stamp);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{channel: ch, time_us: stamp};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    last_sent[ch] = stamp;
  endtask

  // Stops sending and waits until every predicted speed beat has come back.
  // The extra edge first lets the checker count a beat accepted just now.
  // The hold-off afterwards covers an edge still in the block's pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (check_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_pulses(input logic [PPR_W-1:0] pulses);
    cfg_we    <= 1'b1;
    cfg_wdata <= pulses;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Next stamp for a channel. Mostly a forward step, from very short periods
  // (high speeds) to very long ones; the rest repeats the stamp, steps back
  // as a timer wrap would, or jumps to any value at all.
  function automatic logic [TIME_W-1:0] next_stamp(input logic [TIME_W-1:0] prev);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)
      return prev + $urandom_range(1, 2000);
    else if (pick < 70)
      return prev + $urandom_range(2000, 32'h0010_0000);
    else if (pick < 80)
      return prev + $urandom_range(32'h0010_0000, 32'h8000_0000);
    else if (pick < 87)
      return prev;
    else if (pick < 93)
      return prev - $urandom_range(1, 1000);
    else
      return $urandom;
  endfunction

  initial begin : stimulus
    logic [PPR_W-1:0] phase_pulses [PHASES];
    int               phase_idle   [PHASES];
    logic             ch;

    foreach (last_sent[c]) last_sent[c] = '0;

    // The last phase runs with no idling at all, the second one as well.
    phase_pulses = '{PPR_W'($urandom_range(2, 254)), PPR_W'(1),
                     PPR_W'($urandom_range(0, 255)), PPR_W'(255),
                     PPR_W'($urandom_range(1, 16))};
    phase_idle   = '{30, 0, 45, 15, 0};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct <= 25;

    // Directed part at the reset pulse count of one.
    send_edge(1'b0, 32'h0000_0001);  // first edge after reset, shortest period
    send_edge(1'b1, 32'h0000_0000);  // stamp equal to the reset stamp: no beat
    send_edge(1'b1, 32'hFFFF_FFFF);  // longest possible period
    send_edge(1'b1, 32'h0000_0005);  // timer wrap: no beat
    send_edge(1'b1, 32'h0000_0005);  // repeated stamp: no beat
    send_edge(1'b1, 32'h0000_0006);
    send_edge(1'b0, 32'h0000_0001);  // repeated stamp on the other channel
    send_edge(1'b0, 32'h8000_0000);
    send_edge(1'b0, 32'hAAAA_AAAA);
    send_edge(1'b1, 32'h5555_5555);

    // Largest pulse count: the longest period now floors the speed to zero,
    // which is still a beat because the period is not zero.
    settle();
    set_pulses(8'd255);
    send_edge(1'b0, 32'hAAAA_AAAB);
    send_edge(1'b1, 32'h0000_0000);
    send_edge(1'b1, 32'hFFFF_FFFF);

    // A pulse count of zero must scale like one.
    settle();
    set_pulses(8'd0);
    send_edge(1'b0, 32'hAAAA_AAAC);
    send_edge(1'b1, 32'hFFFF_FFFF);
    send_edge(1'b1, 32'h0000_0000);
    send_edge(1'b1, 32'h0000_0007);

    // Random phases. Each one starts from an empty block, so the register
    // write happens while nothing is in flight.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_pulses(phase_pulses[p]);
      idle_pct <= phase_idle[p];
      repeat (ITEMS_PER_PHASE) begin
        ch = 1'($urandom_range(0, CHANNELS - 1));
        send_edge(ch, next_stamp(last_sent[ch]));
      end
    end

    settle();
    if (check_fails == 0 && check_pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
